### rtl/wmf_pkg.sv
`timescale 1ns / 1ps

package wmf_pkg;

    localparam int BYTE_BITS = 8;

    // Handshake state of the two internal stages, passed between control blocks.
    typedef struct packed {
        logic pend_valid;
        logic out_valid;
        logic advance;
        logic accept;
    } wmf_ctrl_t;

endpackage

### rtl/window_mode_filter.sv
`timescale 1ns / 1ps

// Channel    Dir  tdata fields (low bit up)                  tuser  tlast
// s_axis     in   sample[SAMPLE_BITS]                        -      -
// m_axis     out  mode_value[SAMPLE_BITS], mode_count[CNT]   -      -
//
// One word in and one result out per cycle while the output is not stalled: the
// sample is written into the ring register, then the compare/count/argmax logic
// loads the output register. Reset clears the ring to zeros and the write slot to 0.
// A stalled output holds its result; one more word is taken into the ring
// stage, after which s_axis_tready drops until the output drains.
module window_mode_filter #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + wmf_pkg::BYTE_BITS - 1) / wmf_pkg::BYTE_BITS)
                  * wmf_pkg::BYTE_BITS - 1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mode_value, mode_count, zero pad
    output logic [((SAMPLE_BITS + $clog2(WINDOW + 1) + wmf_pkg::BYTE_BITS - 1)
                   / wmf_pkg::BYTE_BITS) * wmf_pkg::BYTE_BITS - 1:0] m_axis_tdata
);

    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int SLOT_BITS = $clog2(WINDOW);
    localparam int M_TDATA_W = ((SAMPLE_BITS + CNT_BITS + wmf_pkg::BYTE_BITS - 1)
                                / wmf_pkg::BYTE_BITS) * wmf_pkg::BYTE_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] window_reg [WINDOW];
    logic [SLOT_BITS-1:0]   write_slot_reg;
    logic                   pend_valid_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] mode_value_reg;
    logic [CNT_BITS-1:0]    mode_count_reg;

    logic [SAMPLE_BITS-1:0] mode_value_next;
    logic [CNT_BITS-1:0]    mode_count_next;
    logic [CNT_BITS-1:0]    slot_count [WINDOW];
    logic [WINDOW-1:0]      match      [WINDOW];

    wmf_pkg::wmf_ctrl_t ctrl;

    always_comb begin
        ctrl.pend_valid = pend_valid_reg;
        ctrl.out_valid  = out_valid_reg;
        ctrl.advance    = !out_valid_reg || m_axis_tready;
        ctrl.accept     = s_axis_tvalid && s_axis_tready;
    end

    assign s_axis_tready = !pend_valid_reg || ctrl.advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({mode_count_reg, mode_value_reg});

    // every slot against every slot
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                match[i][j] = (window_reg[i] == window_reg[j]);
            end
            slot_count[i] = CNT_BITS'($countones(match[i]));
        end
    end

    // strict greater-than in slot order: ties keep the lowest slot
    always_comb begin
        mode_value_next = window_reg[0];
        mode_count_next = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (slot_count[i] > mode_count_next) begin
                mode_count_next = slot_count[i];
                mode_value_next = window_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                window_reg[i] <= '0;
            end
            write_slot_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                window_reg[write_slot_reg] <= s_axis_tdata[SAMPLE_BITS-1:0];
                write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0
                                : write_slot_reg + SLOT_BITS'(1);
            end
            if (ctrl.accept) begin
                pend_valid_reg <= 1'b1;
            end else if (ctrl.advance) begin
                pend_valid_reg <= 1'b0;
            end
            if (ctrl.advance) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance && pend_valid_reg) begin
            mode_value_reg <= mode_value_next;
            mode_count_reg <= mode_count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (mode_count_reg != '0) && (mode_count_reg <= CNT_BITS'(WINDOW)))
        else $error("mode count out of range");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot beyond ring");

    a_slot_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept && (write_slot_reg == LAST_SLOT) |=> write_slot_reg == '0)
        else $error("write slot failed to wrap");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.pend_valid |-> s_axis_tready)
        else $error("ready low with empty ring stage");

    a_pend_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept |=> pend_valid_reg)
        else $error("accepted word not pending");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pend_valid && ctrl.advance |=> ctrl.out_valid)
        else $error("pending result not moved to output");

endmodule
